// File: design/mioi_pkg.sv
package mioi_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int POS_W   = 48;
  localparam int IV_W    = 32;
  localparam int TEMPO_W = 18;
  localparam int CONF_W  = 17;
  localparam int SPB_W   = 32;
  localparam int RATE_W  = 18;
  localparam int AR_W    = 17;
  localparam int HL_W    = 5;
  localparam int DIV_W   = 64;
  localparam int MED_W   = IV_W + 1;
  localparam int ACC_W   = 63;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  localparam logic [RATE_W-1:0]  RATE_RST    = 18'd48000;
  localparam logic [TEMPO_W-1:0] MIN_RST     = 18'd15360;
  localparam logic [TEMPO_W-1:0] MAX_RST     = 18'd51200;
  localparam logic [AR_W-1:0]    AR_RST      = 17'd6554;
  localparam logic [HL_W-1:0]    HL_RST      = 5'd16;
  localparam logic [TEMPO_W-1:0] TEMPO_RST   = 18'd30720;
  localparam logic [AR_W-1:0]    AR_ONE      = 17'd65536;
  localparam logic [DIV_W-1:0]   EST_K       = 64'd30720;
  localparam logic [DIV_W-1:0]   SPB_K       = 64'd15360;
  localparam logic [ACC_W-1:0]   SQ_CAP      = 63'd4611686018427387904;
  localparam logic [ACC_W-1:0]   SQ_CAP_DIV10 = SQ_CAP / 10;
  localparam logic [DIV_W-1:0]   HALF_ROUND  = 64'd32768;

  typedef enum logic [2:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_MIN_TEMPO   = 3'd1,
    REG_MAX_TEMPO   = 3'd2,
    REG_ADAPT_RATE  = 3'd3,
    REG_HIST_LEN    = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FEED,
    ST_FLUSH,
    ST_DRAIN,
    ST_MED,
    ST_EST,
    ST_BLEND1,
    ST_BLEND2,
    ST_VAR,
    ST_CONF1,
    ST_CONF2,
    ST_CONFDIV,
    ST_SPB,
    ST_SPBDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: design/mioi_cell.sv
module mioi_cell
  import mioi_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [IV_W-1:0] in_val_i,
  input  logic            in_vld_i,
  input  logic [IV_W-1:0] next_val_i,
  output logic [IV_W-1:0] val_o,
  output logic [IV_W-1:0] pass_val_o,
  output logic            pass_vld_o
);

  logic            full_q, full_d;
  logic            pvld_q, pvld_d;
  logic [IV_W-1:0] val_q, val_d;
  logic [IV_W-1:0] pval_q, pval_d;

  always_comb begin
    full_d = full_q;
    pvld_d = 1'b0;
    val_d  = val_q;
    pval_d = pval_q;
    if (ctrl_i.clr) begin
      full_d = 1'b0;
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (in_vld_i) begin
      if (!full_q) begin
        val_d  = in_val_i;
        full_d = 1'b1;
      end else if (in_val_i < val_q) begin
        val_d  = in_val_i;
        pval_d = val_q;
        pvld_d = 1'b1;
      end else begin
        pval_d = in_val_i;
        pvld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      full_q <= full_d;
      pvld_q <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pval_q <= pval_d;
  end

  assign val_o      = val_q;
  assign pass_val_o = pval_q;
  assign pass_vld_o = pvld_q;

endmodule

// File: design/mioi_div.sv
module mioi_div
  import mioi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [DIV_W:0]   trial;
  logic             ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[DIV_W-1]};
    ge     = trial >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: design/median_ioi_tempo_estimator.sv
// Tempo estimator fed with onset sample positions, one transaction at a time.
// Every accepted transaction gives exactly one result transaction. An onset
// is shifted into a chain of position registers; when four or more are held,
// the intervals are sorted by a chain of compare-and-pass cells, the median
// is read out of the chain head, and the tempo, confidence and samples per
// beat come from one shared 64-step restoring divider; an onset may run up to
// three divider passes, a clear or a short window at most the one for samples
// per beat. Registers are to be written over the APB port only while no
// transaction is in flight; the block itself does not enforce this.
module median_ioi_tempo_estimator
  import mioi_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEFAULT_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_position
  input  logic                   s_axis_tuser,  // action
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tempo_bpm, confidence, samples_per_beat, estimate_updated, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int D   = WINDOW_DEPTH;
  localparam int NC  = D - 1;
  localparam int CW  = $clog2(D + 1);
  localparam int SW  = $clog2(D + 2);
  localparam int SQW = 2 * (IV_W - 1);
  localparam int RSW = 2 * RATE_W;
  localparam int NAW = RSW + CW;

  // configuration
  logic [RATE_W-1:0]  rate_q;
  logic [TEMPO_W-1:0] min_q, max_q;
  logic [AR_W-1:0]    ar_q;
  logic [HL_W-1:0]    hl_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      min_q  <= MIN_RST;
      max_q  <= MAX_RST;
      ar_q   <= AR_RST;
      hl_q   <= HL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SAMPLE_RATE: rate_q <= pwdata[RATE_W-1:0];
        REG_MIN_TEMPO:   min_q  <= pwdata[TEMPO_W-1:0];
        REG_MAX_TEMPO:   max_q  <= pwdata[TEMPO_W-1:0];
        REG_ADAPT_RATE:  ar_q   <= pwdata[AR_W-1:0];
        REG_HIST_LEN:    hl_q   <= pwdata[HL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SAMPLE_RATE: prdata = APB_DW'(rate_q);
      REG_MIN_TEMPO:   prdata = APB_DW'(min_q);
      REG_MAX_TEMPO:   prdata = APB_DW'(max_q);
      REG_ADAPT_RATE:  prdata = APB_DW'(ar_q);
      REG_HIST_LEN:    prdata = APB_DW'(hl_q);
      default:         prdata = '0;
    endcase
  end

  // state
  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [SW-1:0]      step_q, step_d;
  logic [TEMPO_W-1:0] tempo_q, tempo_d;
  logic [CONF_W-1:0]  conf_q, conf_d;
  logic               upd_q, upd_d;
  logic [SPB_W-1:0]   spb_q, spb_d;
  logic               mvld_q, mvld_d;
  logic [OUT_TDATA_W-1:0] mdata_q, mdata_d;

  logic [POS_W-1:0]   pos_q [D];
  logic [POS_W-1:0]   pos_d [D];
  logic [IV_W-1:0]    ivq_q [NC];
  logic [IV_W-1:0]    ivq_d [NC];
  logic [IV_W-1:0]    iv_new [NC];

  logic [IV_W-1:0]    lo_q, lo_d;
  logic [MED_W-1:0]   med2_q, med2_d;
  logic [TEMPO_W-1:0] est_q, est_d;
  logic [TEMPO_W+AR_W-1:0] p1_q, p1_d, p2_q, p2_d;
  logic [RSW-1:0]     rsq_q, rsq_d;
  logic [NAW-1:0]     na_q, na_d;
  logic [IV_W-2:0]    ad1_q, ad1_d;
  logic               sat1_q, sat1_d, v1_q, v1_d;
  logic [SQW-1:0]     sq_q, sq_d;
  logic               sat2_q, sat2_d, v2_q, v2_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ACC_W-1:0]   b_q, b_d;

  // helpers
  logic [RATE_W-1:0]  rate_e;
  logic [CW-1:0]      heff, c1, n, mid;
  logic [AR_W-1:0]    a_w;
  logic [DIV_W-1:0]   big_a, den_c;
  logic [MED_W-1:0]   t2, ad;
  logic [DIV_W-1:0]   acc_sum, quo_ext;
  logic [TEMPO_W-1:0] est_c;

  // divider
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_num, div_den, div_quo;

  mioi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sorting chain
  cell_ctrl_t         cctrl;
  logic [IV_W-1:0]    cval  [NC];
  logic [IV_W-1:0]    pval  [NC];
  logic               pvld  [NC];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    logic [IV_W-1:0] in_v;
    logic            in_ok;
    logic [IV_W-1:0] nxt;
    if (g == 0) begin : g_head
      assign in_v  = ivq_q[0];
      assign in_ok = (state_q == ST_FEED);
    end else begin : g_body
      assign in_v  = pval[g-1];
      assign in_ok = pvld[g-1];
    end
    if (g == NC - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cval[g+1];
    end
    mioi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cctrl),
      .in_val_i   (in_v),
      .in_vld_i   (in_ok),
      .next_val_i (nxt),
      .val_o      (cval[g]),
      .pass_val_o (pval[g]),
      .pass_vld_o (pvld[g])
    );
  end

  for (genvar g = 0; g < NC; g++) begin : g_iv
    logic [POS_W-1:0] dd;
    assign dd        = pos_q[g] - pos_q[g+1];
    assign iv_new[g] = (|dd[POS_W-1:IV_W]) ? '1 : dd[IV_W-1:0];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = mdata_q;

  always_comb begin
    rate_e = (rate_q == '0) ? RATE_W'(1) : rate_q;
    if (int'(hl_q) > D) heff = CW'(D);
    else if (hl_q == '0) heff = CW'(1);
    else heff = CW'(hl_q);
    c1  = (cnt_q == CW'(D)) ? CW'(D) : cnt_q + 1'b1;
    n   = cnt_q - 1'b1;
    mid = n >> 1;
    a_w = (ar_q > AR_ONE) ? AR_ONE : ar_q;
    big_a = DIV_W'(na_q) << 2;
    den_c = big_a + DIV_W'(b_q);
    t2  = {ivq_q[0], 1'b0};
    ad  = (t2 >= med2_q) ? t2 - med2_q : med2_q - t2;
    acc_sum = DIV_W'(acc_q) + DIV_W'(sq_q);
    quo_ext = div_quo;
    est_c = (quo_ext > DIV_W'(max_q)) ? max_q : quo_ext[TEMPO_W-1:0];
    if (est_c < min_q) est_c = min_q;

    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    tempo_d = tempo_q;
    conf_d  = conf_q;
    upd_d   = upd_q;
    spb_d   = spb_q;
    mvld_d  = mvld_q & ~m_axis_tready;
    mdata_d = mdata_q;
    pos_d   = pos_q;
    ivq_d   = ivq_q;
    lo_d    = lo_q;
    med2_d  = med2_q;
    est_d   = est_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    rsq_d   = rsq_q;
    na_d    = na_q;
    ad1_d   = ad[IV_W-2:0];
    sat1_d  = |ad[MED_W-1:IV_W-1];
    v1_d    = 1'b0;
    sq_d    = SQW'(ad1_q) * SQW'(ad1_q);
    sat2_d  = sat1_q;
    v2_d    = v1_q;
    acc_d   = acc_q;
    b_d     = b_q;
    cctrl   = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            cnt_d   = '0;
            tempo_d = TEMPO_RST;
            conf_d  = '0;
            upd_d   = 1'b0;
            state_d = ST_SPB;
          end else begin
            pos_d[0] = s_axis_tdata;
            for (int i = 1; i < D; i++) pos_d[i] = pos_q[i-1];
            cnt_d   = (c1 > heff) ? heff : c1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (cnt_q < CW'(4)) begin
          upd_d   = 1'b0;
          state_d = ST_SPB;
        end else begin
          ivq_d     = iv_new;
          cctrl.clr = 1'b1;
          step_d    = '0;
          state_d   = ST_FEED;
        end
      end
      ST_FEED: begin
        for (int i = 0; i < NC - 1; i++) ivq_d[i] = ivq_q[i+1];
        ivq_d[NC-1] = '0;
        step_d = step_q + 1'b1;
        if (step_q == SW'(n - 1'b1)) begin
          step_d  = '0;
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        step_d = step_q + 1'b1;
        if (step_q == SW'(D - 1)) begin
          step_d  = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cctrl.shift = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == SW'(mid - 1'b1)) lo_d = cval[0];
        if (step_q == SW'(mid)) begin
          med2_d  = n[0] ? {cval[0], 1'b0} : MED_W'(lo_q) + MED_W'(cval[0]);
          state_d = ST_MED;
        end
      end
      ST_MED: begin
        if (med2_q == '0) begin
          upd_d   = 1'b0;
          state_d = ST_SPB;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(rate_e) * EST_K;
          div_den   = DIV_W'(med2_q);
          state_d   = ST_EST;
        end
      end
      ST_EST: begin
        if (div_done) begin
          est_d   = est_c;
          state_d = ST_BLEND1;
        end
      end
      ST_BLEND1: begin
        p1_d    = (TEMPO_W+AR_W)'(tempo_q) * (TEMPO_W+AR_W)'(AR_ONE - a_w);
        p2_d    = (TEMPO_W+AR_W)'(est_q) * (TEMPO_W+AR_W)'(a_w);
        state_d = ST_BLEND2;
      end
      ST_BLEND2: begin
        tempo_d = TEMPO_W'((DIV_W'(p1_q) + DIV_W'(p2_q) + HALF_ROUND) >> 16);
        rsq_d   = RSW'(rate_e) * RSW'(rate_e);
        ivq_d   = iv_new;
        acc_d   = '0;
        step_d  = '0;
        state_d = ST_VAR;
      end
      ST_VAR: begin
        na_d = NAW'(rsq_q) * NAW'(n);
        for (int i = 0; i < NC - 1; i++) ivq_d[i] = ivq_q[i+1];
        ivq_d[NC-1] = '0;
        v1_d   = (step_q < SW'(n));
        step_d = step_q + 1'b1;
        if (v2_q) begin
          if (sat2_q || acc_sum >= DIV_W'(SQ_CAP)) acc_d = SQ_CAP;
          else acc_d = acc_sum[ACC_W-1:0];
        end
        if (step_q == SW'(n + 2'd2)) state_d = ST_CONF1;
      end
      ST_CONF1: begin
        b_d     = (acc_q > SQ_CAP_DIV10) ? SQ_CAP : (acc_q << 3) + (acc_q << 1);
        state_d = ST_CONF2;
      end
      ST_CONF2: begin
        upd_d = 1'b1;
        if (b_q[ACC_W-1] || b_q[ACC_W-2]) begin
          conf_d  = '0;
          state_d = ST_SPB;
        end else begin
          div_start = 1'b1;
          div_num   = (big_a << 16) + (den_c >> 1);
          div_den   = den_c;
          state_d   = ST_CONFDIV;
        end
      end
      ST_CONFDIV: begin
        if (div_done) begin
          conf_d  = div_quo[CONF_W-1:0];
          state_d = ST_SPB;
        end
      end
      ST_SPB: begin
        if (tempo_q == '0) begin
          spb_d   = '0;
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(rate_e) * SPB_K;
          div_den   = DIV_W'(tempo_q);
          state_d   = ST_SPBDIV;
        end
      end
      ST_SPBDIV: begin
        if (div_done) begin
          spb_d   = (|div_quo[DIV_W-1:SPB_W]) ? '1 : div_quo[SPB_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!mvld_q || m_axis_tready) begin
          mdata_d = OUT_TDATA_W'({upd_q, spb_q, conf_q, tempo_q});
          mvld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      tempo_q <= TEMPO_RST;
      conf_q  <= '0;
      upd_q   <= 1'b0;
      mvld_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      tempo_q <= tempo_d;
      conf_q  <= conf_d;
      upd_q   <= upd_d;
      mvld_q  <= mvld_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    ivq_q   <= ivq_d;
    spb_q   <= spb_d;
    mdata_q <= mdata_d;
    lo_q    <= lo_d;
    med2_q  <= med2_d;
    est_q   <= est_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    rsq_q   <= rsq_d;
    na_q    <= na_d;
    ad1_q   <= ad1_d;
    sat1_q  <= sat1_d;
    sq_q    <= sq_d;
    sat2_q  <= sat2_d;
    acc_q   <= acc_d;
    b_q     <= b_d;
  end

endmodule

// File: design/mioi_checker.sv
module mioi_checker
  import mioi_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   pready
);

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_conf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[TEMPO_W+CONF_W-1:TEMPO_W] <= CONF_W'(65536))
    else $error("confidence above one");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:TEMPO_W+CONF_W+SPB_W+1] == '0)
    else $error("pad bits set");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind median_ioi_tempo_estimator mioi_checker u_mioi_checker (.*);

// File: tb/median_ioi_tempo_checker.sv
module median_ioi_tempo_checker
  import mioi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_position
  input  logic                   s_axis_tuser,  // action
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tempo_bpm, confidence, samples_per_beat, estimate_updated, zero pad
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  input  logic                   pready,
  output int                     fail_count,
  output int                     pending,
  output int                     updates_seen
);

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam longint unsigned POS_MASK = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned IV_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned CAP = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo;
    logic [CONF_W-1:0]  conf;
    logic [SPB_W-1:0]   spb;
    logic               updated;
  } tempo_report_t;

  tempo_report_t tempo_reports_q[$];

  longint unsigned onsets[DEPTH];
  int unsigned     onset_cnt, head_slot;
  longint unsigned cur_tempo, cur_conf;
  longint unsigned cfg_rate, cfg_min, cfg_max, cfg_adapt, cfg_hist;

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic longint unsigned rate_eff();
    return (cfg_rate == 0) ? 1 : cfg_rate;
  endfunction

  function automatic bit estimate_tempo();
    longint unsigned ivs[DEPTH], srt[DEPTH];
    longint unsigned d, key, med2, est, a, acc, b, big_a, den, t, ad;
    int unsigned n, j;
    if (onset_cnt < 4) return 0;
    n = onset_cnt - 1;
    for (int i = 0; i < n; i++) begin
      d = (onsets[(head_slot + i + 1) % DEPTH] - onsets[(head_slot + i) % DEPTH]) & POS_MASK;
      if (d > IV_MAX) d = IV_MAX;
      ivs[i] = d;
      srt[i] = d;
    end
    for (int i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    med2 = (n % 2) ? 2 * srt[n/2] : srt[n/2-1] + srt[n/2];
    if (med2 == 0) return 0;
    est = (30720 * rate_eff()) / med2;
    if (est > cfg_max) est = cfg_max;
    if (est < cfg_min) est = cfg_min;
    a = (cfg_adapt > 65536) ? 65536 : cfg_adapt;
    cur_tempo = (cur_tempo * (65536 - a) + est * a + 32768) >> 16;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      t = 2 * ivs[i];
      ad = (t >= med2) ? t - med2 : med2 - t;
      if (ad >= 64'h8000_0000) begin
        acc = CAP;
        break;
      end
      acc = (acc + ad * ad >= CAP) ? CAP : acc + ad * ad;
    end
    b = (acc > CAP / 10) ? CAP : acc * 10;
    big_a = 4 * longint'(n) * rate_eff() * rate_eff();
    if (b >= (CAP >> 1)) cur_conf = 0;
    else begin
      den = big_a + b;
      cur_conf = ((big_a << 16) + den / 2) / den;
    end
    return 1;
  endfunction

  function automatic tempo_report_t step_estimator(bit clr, longint unsigned pos);
    tempo_report_t r;
    longint unsigned spb;
    int unsigned lim;
    r.updated = 0;
    if (clr) begin
      onset_cnt = 0;
      head_slot = 0;
      cur_tempo = TEMPO_RST;
      cur_conf = 0;
    end else begin
      lim = (cfg_hist > DEPTH) ? DEPTH : ((cfg_hist == 0) ? 1 : cfg_hist);
      if (onset_cnt >= DEPTH) begin
        onsets[head_slot] = pos;
        head_slot = (head_slot + 1) % DEPTH;
      end else begin
        onsets[(head_slot + onset_cnt) % DEPTH] = pos;
        onset_cnt++;
      end
      while (onset_cnt > lim) begin
        head_slot = (head_slot + 1) % DEPTH;
        onset_cnt--;
      end
      r.updated = estimate_tempo();
    end
    if (cur_tempo == 0) spb = 0;
    else begin
      spb = (15360 * rate_eff()) / cur_tempo;
      if (spb > IV_MAX) spb = IV_MAX;
    end
    r.tempo = cur_tempo[TEMPO_W-1:0];
    r.conf = cur_conf[CONF_W-1:0];
    r.spb = spb[SPB_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tempo_report_t want, got;
    if (!rst_ni) begin
      tempo_reports_q.delete();
      onset_cnt = 0;
      head_slot = 0;
      cur_tempo = TEMPO_RST;
      cur_conf = 0;
      cfg_rate = RATE_RST;
      cfg_min = MIN_RST;
      cfg_max = MAX_RST;
      cfg_adapt = AR_RST;
      cfg_hist = HL_RST;
      fail_count = 0;
      updates_seen = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_AW-1:2]))
          REG_SAMPLE_RATE: cfg_rate = pwdata[RATE_W-1:0];
          REG_MIN_TEMPO:   cfg_min = pwdata[TEMPO_W-1:0];
          REG_MAX_TEMPO:   cfg_max = pwdata[TEMPO_W-1:0];
          REG_ADAPT_RATE:  cfg_adapt = pwdata[AR_W-1:0];
          REG_HIST_LEN:    cfg_hist = pwdata[HL_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        tempo_reports_q.insert(tempo_reports_q.size(),
                               step_estimator(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.tempo = m_axis_tdata[17:0];
        got.conf = m_axis_tdata[34:18];
        got.spb = m_axis_tdata[66:35];
        got.updated = m_axis_tdata[67];
        if (tempo_reports_q.size() == 0) begin
          note_mismatch("result transaction with nothing expected", 1, 0);
        end else begin
          want = tempo_reports_q.pop_front();
          if (got.updated) updates_seen++;
          if (got.tempo !== want.tempo) note_mismatch("tempo_bpm", got.tempo, want.tempo);
          if (got.conf !== want.conf) note_mismatch("confidence", got.conf, want.conf);
          if (got.spb !== want.spb) note_mismatch("samples_per_beat", got.spb, want.spb);
          if (got.updated !== want.updated)
            note_mismatch("estimate_updated", got.updated, want.updated);
          if (m_axis_tdata[71:68] !== 4'd0) note_mismatch("pad", m_axis_tdata[71:68], 0);
        end
      end
      pending = tempo_reports_q.size();
    end
  end

endmodule

// File: tb/median_ioi_tempo_estimator_tb.sv
module median_ioi_tempo_estimator_tb;
  import mioi_pkg::*;

  logic                   clk_i = 0;
  logic                   rst_ni = 0;
  logic                   s_axis_tvalid = 0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  int                     fail_count, pending, updates_seen;
  bit                     calm = 0, hold_req = 0, hold_done = 0;
  int                     onsets_sent = 0, clears_sent = 0, settings_used = 0;

  localparam bit ACT_ONSET = 1'b0;
  localparam bit ACT_CLEAR = 1'b1;

  always #1 clk_i = ~clk_i;

  median_ioi_tempo_estimator uut (.*);

  median_ioi_tempo_checker chk (.*);

  initial begin
    #5000000;
    $display("[median_ioi_tempo_estimator] ERROR");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 0;
        repeat (2000) @(posedge clk_i);
        hold_done = 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 7);
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [APB_DW-1:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic load_setting(int rate, int mn, int mx, int ar, int hl);
    drain_results();
    reg_write(REG_SAMPLE_RATE, rate);
    reg_write(REG_MIN_TEMPO, mn);
    reg_write(REG_MAX_TEMPO, mx);
    reg_write(REG_ADAPT_RATE, ar);
    reg_write(REG_HIST_LEN, hl);
    settings_used++;
  endtask

  task automatic send_item(bit act, logic [47:0] pos);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tdata <= pos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == ACT_CLEAR) clears_sent++;
    else onsets_sent++;
  endtask

  task automatic beat_train(int len, logic [47:0] start, int period, int jitter);
    logic [47:0] p;
    p = start;
    for (int i = 0; i < len; i++) begin
      send_item(ACT_ONSET, p);
      p = p + 48'(period) + 48'($urandom_range(0, 2 * jitter)) - 48'(jitter);
    end
  endtask

  initial begin
    int kind, total;
    logic [47:0] pmax;
    pmax = '1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: steady train, zero intervals, wraparound, saturation, clear
    beat_train(6, 48'd0, 24000, 0);
    send_item(ACT_CLEAR, pmax);
    for (int i = 0; i < 5; i++) send_item(ACT_ONSET, 48'd1000);
    send_item(ACT_CLEAR, 48'd0);
    beat_train(5, pmax - 48'd40000, 22050, 100);
    send_item(ACT_ONSET, 48'd0);
    send_item(ACT_ONSET, 48'h0001_0000_0000);
    send_item(ACT_ONSET, pmax);

    load_setting(0, 0, 0, 65536, 0);
    beat_train(6, 48'd100, 3, 2);
    load_setting(262143, 262143, 0, 131071, 31);
    beat_train(8, 48'd5, 7, 3);
    load_setting(44100, 100, 262143, 0, 4);
    beat_train(7, 48'd0, 11025, 500);
    load_setting(48000, 15360, 51200, 6554, 16);

    // long receiver hold-off while onsets keep coming
    hold_req = 1;
    beat_train(12, 48'd777, 12000, 300);
    while (!hold_done) @(posedge clk_i);

    total = 0;
    while (total < 880) begin
      if (total >= 750) calm = 1;
      if (total % 150 == 149 || $urandom_range(0, 150) == 0) begin
        case ($urandom_range(0, 4))
          0: load_setting($urandom_range(1, 262143), $urandom_range(0, 30000),
                          $urandom_range(30000, 262143), $urandom_range(0, 65536),
                          $urandom_range(4, 16));
          1: load_setting($urandom_range(0, 3), $urandom_range(0, 262143),
                          $urandom_range(0, 262143), $urandom_range(65537, 131071),
                          $urandom_range(0, 3));
          2: load_setting(262143, 0, 262143, 65536, $urandom_range(17, 31));
          default: load_setting(48000, 15360, 51200, $urandom_range(1000, 20000),
                                $urandom_range(4, 16));
        endcase
        total++;
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        int len;
        len = $urandom_range(5, 20);
        beat_train(len, 48'({$urandom, $urandom}), $urandom_range(1, 100000),
                   $urandom_range(0, 2000));
        total += len;
      end else if (kind < 83) begin
        send_item(ACT_CLEAR, 48'({$urandom, $urandom}));
        total++;
      end else begin
        send_item(ACT_ONSET, 48'({$urandom, $urandom}));
        total++;
      end
    end

    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("covered %0d onsets, %0d clears, %0d register settings, %0d new estimates",
             onsets_sent, clears_sent, settings_used, updates_seen);
    $display("including a long result-side hold-off and random idle bursts on both sides");
    if (fail_count == 0) $display("[median_ioi_tempo_estimator] OK");
    else $display("[median_ioi_tempo_estimator] ERROR");
    $finish;
  end

endmodule
